@@ rtl/ucfp_pkg.sv @@
package ucfp_pkg;

	typedef logic [7:0] byte_t;

	// Default store depth and the reset value of the silence register.
	localparam int FRAME_DEPTH_DEF   = 32;
	localparam logic [15:0] SILENCE_RST = 16'd300;

	// Frame head codes.
	localparam byte_t HEAD_SET  = 8'hAA;
	localparam byte_t HEAD_GETP = 8'h55;
	localparam byte_t HEAD_GETV = 8'hA5;

	// Accepted frame lengths.
	localparam int LEN_SET = 11;
	localparam int LEN_GET = 2;

	// Last store index that the parameters of a SET frame occupy.
	localparam int SET_LAST_IDX = 9;

	// Reply lengths and the width of the reply counter.
	localparam int CNT_W          = 4;
	localparam int REPLY_GETP_LEN = 11;
	localparam int REPLY_GETV_LEN = 4;

	// Result kinds.
	localparam logic KIND_TX   = 1'b0;
	localparam logic KIND_SAVE = 1'b1;

endpackage

@@ rtl/ucfp_store.sv @@
module ucfp_store
	import ucfp_pkg::*;
#(
	parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(FRAME_DEPTH)-1:0] wr_addr,
	input  byte_t                          wr_data,
	input  logic                           rd_en,
	input  logic [$clog2(FRAME_DEPTH)-1:0] rd_addr,
	output byte_t                          rd_data
);

	byte_t mem_q [FRAME_DEPTH];
	byte_t rd_data_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/uart_command_frame_parser_core.sv @@
// Channel  | Handshake                     | Payload
// ---------+-------------------------------+----------------------------------------------
// input    | in_valid, in_stall (driven)   | command, rx_byte, vdc_sample
// output   | out_valid, out_stall (sensed) | kind, tx_byte, last, vdc_*, chopper_on
// config   | wr_en                         | wr_data (silence_ticks)
//
// A byte item, and a tick item that ends no frame, leaves the block idle and ready for the next item.
// A tick item that ends a frame walks the store through its single read port, one byte a
// cycle, then loads the parameters of a SET frame or emits the reply bytes, each held while
// out_stall is high, and last hands the final result over.
// Output stalls hold the block; in_stall stays high until the last result has been taken.
// Reset clears the control state and the parameters; the frame store is not cleared.
module uart_command_frame_parser_core
	import ucfp_pkg::*;
#(
	parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [15:0] wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] vdc_sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  tx_byte,
	output logic        last,
	output logic [15:0] vdc_min,
	output logic [15:0] vdc_max,
	output logic [15:0] vdc_critic,
	output logic [15:0] vdc_speed,
	output logic        chopper_on
);

	localparam int IDX_W = $clog2(FRAME_DEPTH);
	localparam int LEN_W = $clog2(FRAME_DEPTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_EMIT  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;

	logic [2:0]       state_q;
	logic             phase_q;
	logic [15:0]      silence_ticks_q;
	logic [15:0]      silence_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] idx_q;
	logic [LEN_W-1:0] tag_q;
	logic             pend_q;
	byte_t            acc_q;
	byte_t            head_q;
	logic [15:0]      vdc_q;
	logic             reply_vdc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      min_q, max_q, crit_q, speed_q;
	logic             chop_q;
	logic             out_valid_q, kind_q, last_q;
	byte_t            tx_byte_q;

	logic             in_acc, out_acc;
	logic [15:0]      silence_inc;
	logic             timeout;
	logic             st_wr;
	logic             st_rd;
	logic [LEN_W-1:0] rd_limit;
	byte_t            rd_data;
	logic             frame_good, is_set, is_getp, is_getv;
	byte_t            reply_sel, reply_byte;
	logic [CNT_W-1:0] reply_end;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;

	// Saturating silence count and the timeout compare, evaluated on ticks.
	assign silence_inc = (silence_q == 16'hFFFF) ? silence_q : silence_q + 16'd1;
	assign timeout     = silence_inc >= silence_ticks_q;

	// Bytes are stored while the store has room.
	assign st_wr = in_acc && !command && (len_q < LEN_W'(FRAME_DEPTH));

	// The read port steps through the frame while scanning or loading.
	assign rd_limit = (state_q == ST_LOAD) ? LEN_W'(SET_LAST_IDX + 1) : len_q;
	assign st_rd    = ((state_q == ST_SCAN) || (state_q == ST_LOAD)) && (idx_q < rd_limit);

	ucfp_store #(
		.FRAME_DEPTH(FRAME_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (st_wr),
		.wr_addr(len_q[IDX_W-1:0]),
		.wr_data(rx_byte),
		.rd_en  (st_rd),
		.rd_addr(idx_q[IDX_W-1:0]),
		.rd_data(rd_data)
	);

	// Frame check and command decode, valid once the scan has finished.
	always_comb begin
		frame_good = (acc_q == 8'h00) && (head_q inside {HEAD_SET, HEAD_GETP, HEAD_GETV})
			&& ((len_q == LEN_W'(LEN_SET)) || (len_q == LEN_W'(LEN_GET)));
		is_set  = (head_q == HEAD_SET) && (len_q == LEN_W'(LEN_SET));
		is_getp = (head_q == HEAD_GETP) && (len_q == LEN_W'(LEN_GET));
		is_getv = (head_q == HEAD_GETV) && (len_q == LEN_W'(LEN_GET));
	end

	// Reply byte for the current count; the final byte is the running checksum.
	always_comb begin
		reply_sel = 8'h00;
		if (reply_vdc_q) begin
			reply_end = CNT_W'(REPLY_GETV_LEN - 1);
			case (cnt_q)
				4'd0:    reply_sel = HEAD_GETV;
				4'd1:    reply_sel = vdc_q[15:8];
				4'd2:    reply_sel = vdc_q[7:0];
				default: reply_sel = 8'h00;
			endcase
		end else begin
			reply_end = CNT_W'(REPLY_GETP_LEN - 1);
			case (cnt_q)
				4'd0:    reply_sel = HEAD_GETP;
				4'd1:    reply_sel = min_q[15:8];
				4'd2:    reply_sel = min_q[7:0];
				4'd3:    reply_sel = max_q[15:8];
				4'd4:    reply_sel = max_q[7:0];
				4'd5:    reply_sel = crit_q[15:8];
				4'd6:    reply_sel = crit_q[7:0];
				4'd7:    reply_sel = speed_q[15:8];
				4'd8:    reply_sel = speed_q[7:0];
				4'd9:    reply_sel = {7'd0, chop_q};
				default: reply_sel = 8'h00;
			endcase
		end
		reply_byte = (cnt_q == reply_end) ? acc_q : reply_sel;
	end

	// Payload registers that need no reset.
	always_ff @(posedge clk) begin
		if (in_acc && command) begin
			vdc_q <= vdc_sample;
		end
		if (st_rd) begin
			tag_q <= idx_q;
		end
	end

	// Sequencer around the shared read port and XOR accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			phase_q         <= 1'b0;
			silence_ticks_q <= SILENCE_RST;
			silence_q       <= 16'd0;
			len_q           <= '0;
			idx_q           <= '0;
			pend_q          <= 1'b0;
			acc_q           <= 8'h00;
			head_q          <= 8'h00;
			reply_vdc_q     <= 1'b0;
			cnt_q           <= '0;
			min_q           <= 16'd0;
			max_q           <= 16'd0;
			crit_q          <= 16'd0;
			speed_q         <= 16'd0;
			chop_q          <= 1'b0;
			out_valid_q     <= 1'b0;
			kind_q          <= KIND_TX;
			last_q          <= 1'b0;
			tx_byte_q       <= 8'h00;
		end else begin
			if (wr_en) begin
				silence_ticks_q <= wr_data;
			end
			if (out_acc && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			if (st_rd) begin
				idx_q <= idx_q + LEN_W'(1);
			end
			pend_q <= st_rd;

			case (state_q)
				ST_IDLE: begin
					if (in_acc && !command) begin
						silence_q <= 16'd0;
						if (st_wr) begin
							len_q <= len_q + LEN_W'(1);
						end
					end else if (in_acc) begin
						silence_q <= silence_inc;
						if (timeout) begin
							if (!phase_q) begin
								len_q   <= '0;
								phase_q <= 1'b1;
							end else if (len_q != '0) begin
								idx_q   <= '0;
								acc_q   <= 8'h00;
								state_q <= ST_SCAN;
							end
						end
					end
				end

				ST_SCAN: begin
					// XOR every stored byte and keep the head byte.
					if (pend_q) begin
						acc_q <= acc_q ^ rd_data;
						if (tag_q == '0) begin
							head_q <= rd_data;
						end
					end
					if (!st_rd && !pend_q) begin
						if (!frame_good) begin
							len_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							silence_q <= 16'd0;
							phase_q   <= 1'b0;
							acc_q     <= 8'h00;
							cnt_q     <= '0;
							if (is_set) begin
								idx_q   <= LEN_W'(1);
								state_q <= ST_LOAD;
							end else if (is_getp) begin
								reply_vdc_q <= 1'b0;
								state_q     <= ST_EMIT;
							end else if (is_getv) begin
								reply_vdc_q <= 1'b1;
								state_q     <= ST_EMIT;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end

				ST_LOAD: begin
					// Big-endian parameter words from store bytes one to eight, the chopper flag from byte nine.
					if (pend_q) begin
						case (tag_q[3:0])
							4'd1:    min_q[15:8]   <= rd_data;
							4'd2:    min_q[7:0]    <= rd_data;
							4'd3:    max_q[15:8]   <= rd_data;
							4'd4:    max_q[7:0]    <= rd_data;
							4'd5:    crit_q[15:8]  <= rd_data;
							4'd6:    crit_q[7:0]   <= rd_data;
							4'd7:    speed_q[15:8] <= rd_data;
							4'd8:    speed_q[7:0]  <= rd_data;
							4'd9:    chop_q        <= (rd_data != 8'h00);
							default: chop_q        <= chop_q;
						endcase
					end
					if (!st_rd && !pend_q) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_SAVE;
						tx_byte_q   <= 8'h00;
						last_q      <= 1'b1;
						state_q     <= ST_DRAIN;
					end
				end

				ST_EMIT: begin
					// One reply byte per hand-over, checksum built on the way.
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_TX;
						tx_byte_q   <= reply_byte;
						last_q      <= (cnt_q == reply_end);
						acc_q       <= acc_q ^ reply_byte;
						cnt_q       <= cnt_q + CNT_W'(1);
						if (cnt_q == reply_end) begin
							state_q <= ST_DRAIN;
						end
					end
				end

				ST_DRAIN: begin
					if (out_acc) begin
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign tx_byte    = tx_byte_q;
	assign last       = last_q;
	assign vdc_min    = min_q;
	assign vdc_max    = max_q;
	assign vdc_critic = crit_q;
	assign vdc_speed  = speed_q;
	assign chopper_on = chop_q;

	// No new item is taken while a result is still on offer.
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid_q)
		else $error("input accepted while a result is pending");

	// A save report is always the only and final result.
	a_save_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_SAVE) |-> last_q)
		else $error("save report not marked last");

	// A frame is only checked while reading frames.
	a_scan_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> phase_q)
		else $error("frame check outside the read phase");

	// The fill count never passes the store depth.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(FRAME_DEPTH))
		else $error("frame length beyond store depth");

endmodule

@@ sim/uart_command_frame_parser_core_test.sv @@
module uart_command_frame_parser_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ucfp_pkg::*;

	// Item commands on the input channel.
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 64;
	localparam int REPLY_TARGET  = 60;
	localparam int MAX_SHOWN     = 50;

	typedef struct packed {
		logic        kind;
		byte_t       data;
		logic        fin;
		logic [15:0] vmin;
		logic [15:0] vmax;
		logic [15:0] vcrit;
		logic [15:0] vspeed;
		logic        chop;
	} reply_t;

	typedef struct packed {
		logic        cmd;
		byte_t       rx;
		logic [15:0] vdc;
		logic [3:0]  n_typed;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [15:0] wr_data = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        command = CMD_BYTE;
	logic [7:0]  rx_byte = 8'h00;
	logic [15:0] vdc_sample = 16'h0000;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kind;
	logic [7:0]  tx_byte;
	logic        last;
	logic [15:0] vdc_min;
	logic [15:0] vdc_max;
	logic [15:0] vdc_critic;
	logic [15:0] vdc_speed;
	logic        chopper_on;

	uart_command_frame_parser_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_data    (wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.rx_byte    (rx_byte),
		.vdc_sample (vdc_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.tx_byte    (tx_byte),
		.last       (last),
		.vdc_min    (vdc_min),
		.vdc_max    (vdc_max),
		.vdc_critic (vdc_critic),
		.vdc_speed  (vdc_speed),
		.chopper_on (chopper_on)
	);

	always #1 clk = ~clk;

	// Parser state as the testbench sees it, starting from the reset values.
	logic [15:0] sil_limit = SILENCE_RST;
	logic        waiting_idle = 1'b1;
	logic [15:0] quiet_ticks = 16'd0;
	byte_t       frame_buf [64];
	logic [5:0]  frame_len = 6'd0;
	logic [15:0] p_min = 16'd0;
	logic [15:0] p_max = 16'd0;
	logic [15:0] p_crit = 16'd0;
	logic [15:0] p_speed = 16'd0;
	logic        chop = 1'b0;
	reply_t      step_out [11];

	reply_t      pending_replies [$];
	int          mismatches = 0;
	int          replies_seen = 0;
	int          replies_due = 0;
	int          items_sent = 0;
	int          rand_items = 0;
	int          settings_used = 0;
	int          cycles = 0;
	int          typed_pos = 0;
	int          stall_left = 0;
	bit          idle_on = 1'b0;
	bit          quiet = 1'b0;

	// Directed items, walked in order with the silence limit at one tick.
	dir_row_t dir_tab [25] = '{
		'{CMD_TICK, 8'h00, 16'h0000, 4'd0},
		'{CMD_BYTE, HEAD_GETP, 16'h0000, 4'd0},
		'{CMD_BYTE, HEAD_GETP, 16'h0000, 4'd0},
		'{CMD_TICK, 8'h00, 16'h0000, 4'd11},
		'{CMD_TICK, 8'h00, 16'h0000, 4'd0},
		'{CMD_BYTE, HEAD_SET, 16'h0000, 4'd0},
		'{CMD_BYTE, 8'hFF, 16'h0000, 4'd0},
		'{CMD_BYTE, 8'hFF, 16'h0000, 4'd0},
		'{CMD_BYTE, 8'hFF, 16'h0000, 4'd0},
		'{CMD_BYTE, 8'hFF, 16'h0000, 4'd0},
		'{CMD_BYTE, 8'hFF, 16'h0000, 4'd0},
		'{CMD_BYTE, 8'hFF, 16'h0000, 4'd0},
		'{CMD_BYTE, 8'hFF, 16'h0000, 4'd0},
		'{CMD_BYTE, 8'hFF, 16'h0000, 4'd0},
		'{CMD_BYTE, 8'h01, 16'h0000, 4'd0},
		'{CMD_BYTE, 8'hAB, 16'h0000, 4'd0},
		'{CMD_TICK, 8'h00, 16'h0000, 4'd1},
		'{CMD_TICK, 8'h00, 16'h0000, 4'd0},
		'{CMD_BYTE, HEAD_GETV, 16'h0000, 4'd0},
		'{CMD_BYTE, HEAD_GETV, 16'h0000, 4'd0},
		'{CMD_TICK, 8'h00, 16'hFFFF, 4'd4},
		'{CMD_TICK, 8'h00, 16'h0000, 4'd0},
		'{CMD_BYTE, HEAD_SET, 16'h0000, 4'd0},
		'{CMD_BYTE, HEAD_SET, 16'h0000, 4'd0},
		'{CMD_TICK, 8'h00, 16'h0000, 4'd0}
	};

	// Replies that follow directly from the directed rows: a parameter read just after
	// reset, a SET with every parameter bit high, and a voltage read at full scale.
	reply_t typed_tab [16] = '{
		'{KIND_TX, 8'h55, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0},
		'{KIND_TX, 8'h00, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0},
		'{KIND_TX, 8'h00, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0},
		'{KIND_TX, 8'h00, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0},
		'{KIND_TX, 8'h00, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0},
		'{KIND_TX, 8'h00, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0},
		'{KIND_TX, 8'h00, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0},
		'{KIND_TX, 8'h00, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0},
		'{KIND_TX, 8'h00, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0},
		'{KIND_TX, 8'h00, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0},
		'{KIND_TX, 8'h55, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0},
		'{KIND_SAVE, 8'h00, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1},
		'{KIND_TX, 8'hA5, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1},
		'{KIND_TX, 8'hFF, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1},
		'{KIND_TX, 8'hFF, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1},
		'{KIND_TX, 8'hA5, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}
	};

	// Silence limits of the random phases; zero makes every tick a timeout.
	logic [15:0] sil_list [5] = '{16'd2, 16'd0, 16'd1, 16'd5, 16'd3};

	function automatic reply_t mk_reply(logic k, byte_t d, logic f);
		reply_t r;
		r.kind   = k;
		r.data   = d;
		r.fin    = f;
		r.vmin   = p_min;
		r.vmax   = p_max;
		r.vcrit  = p_crit;
		r.vspeed = p_speed;
		r.chop   = chop;
		return r;
	endfunction

	// Advances the parser state by one item and leaves its replies in step_out.
	function automatic int parse_item(logic cmd, byte_t rx, logic [15:0] vdc);
		byte_t rep [11];
		byte_t x;
		byte_t head;
		int    n;
		int    i;
		if (cmd == CMD_BYTE) begin
			quiet_ticks = 16'd0;
			if (frame_len < FRAME_DEPTH_DEF) begin
				frame_buf[frame_len] = rx;
				frame_len = frame_len + 6'd1;
			end
			return 0;
		end
		if (quiet_ticks != 16'hFFFF)
			quiet_ticks = quiet_ticks + 16'd1;
		if (quiet_ticks < sil_limit)
			return 0;
		// The first timeout only clears whatever arrived while the line was busy.
		if (waiting_idle) begin
			frame_len = 6'd0;
			waiting_idle = 1'b0;
			return 0;
		end
		if (frame_len == 6'd0)
			return 0;
		x = 8'h00;
		for (i = 0; i < frame_len; i++)
			x ^= frame_buf[i];
		head = frame_buf[0];
		if (x != 8'h00 || !(head == HEAD_SET || head == HEAD_GETP || head == HEAD_GETV) ||
				!(frame_len == LEN_SET || frame_len == LEN_GET)) begin
			frame_len = 6'd0;
			return 0;
		end
		quiet_ticks = 16'd0;
		waiting_idle = 1'b1;
		if (head == HEAD_SET && frame_len == LEN_SET) begin
			p_min   = {frame_buf[1], frame_buf[2]};
			p_max   = {frame_buf[3], frame_buf[4]};
			p_crit  = {frame_buf[5], frame_buf[6]};
			p_speed = {frame_buf[7], frame_buf[8]};
			chop    = (frame_buf[9] != 8'h00);
			step_out[0] = mk_reply(KIND_SAVE, 8'h00, 1'b1);
			return 1;
		end
		if (head == HEAD_GETP && frame_len == LEN_GET) begin
			rep[0] = HEAD_GETP;
			rep[1] = p_min[15:8];
			rep[2] = p_min[7:0];
			rep[3] = p_max[15:8];
			rep[4] = p_max[7:0];
			rep[5] = p_crit[15:8];
			rep[6] = p_crit[7:0];
			rep[7] = p_speed[15:8];
			rep[8] = p_speed[7:0];
			rep[9] = {7'd0, chop};
			x = 8'h00;
			for (i = 0; i < 10; i++)
				x ^= rep[i];
			rep[10] = x;
			n = REPLY_GETP_LEN;
		end else if (head == HEAD_GETV && frame_len == LEN_GET) begin
			rep[0] = HEAD_GETV;
			rep[1] = vdc[15:8];
			rep[2] = vdc[7:0];
			rep[3] = rep[0] ^ rep[1] ^ rep[2];
			n = REPLY_GETV_LEN;
		end else begin
			// Head and length do not pair up: the frame is dropped without a reply.
			return 0;
		end
		for (i = 0; i < n; i++)
			step_out[i] = mk_reply(KIND_TX, rep[i], i == n - 1);
		return n;
	endfunction

	task automatic note_mismatch(string what, logic [15:0] got, logic [15:0] want);
		if (mismatches < MAX_SHOWN)
			$display("MISMATCH at cycle %0d, %s: got %h, expected %h", cycles, what, got, want);
		mismatches++;
	endtask

	task automatic check_reply(reply_t got);
		reply_t want;
		if (pending_replies.size() == 0) begin
			note_mismatch("reply with none outstanding", 16'(got.data), 16'd0);
		end else begin
			want = pending_replies.pop_front();
			if (got.kind !== want.kind)
				note_mismatch("kind", 16'(got.kind), 16'(want.kind));
			if (got.data !== want.data)
				note_mismatch("tx_byte", 16'(got.data), 16'(want.data));
			if (got.fin !== want.fin)
				note_mismatch("last", 16'(got.fin), 16'(want.fin));
			if (got.vmin !== want.vmin)
				note_mismatch("vdc_min", got.vmin, want.vmin);
			if (got.vmax !== want.vmax)
				note_mismatch("vdc_max", got.vmax, want.vmax);
			if (got.vcrit !== want.vcrit)
				note_mismatch("vdc_critic", got.vcrit, want.vcrit);
			if (got.vspeed !== want.vspeed)
				note_mismatch("vdc_speed", got.vspeed, want.vspeed);
			if (got.chop !== want.chop)
				note_mismatch("chopper_on", 16'(got.chop), 16'(want.chop));
		end
	endtask

	// Offers one item, holds it until taken, then records the replies it must cause.
	task automatic send_item(logic cmd, byte_t rx, logic [15:0] vdc, int n_typed);
		int n;
		int k;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		rx_byte    <= rx;
		vdc_sample <= vdc;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n = parse_item(cmd, rx, vdc);
		if (n_typed > 0) begin
			for (k = 0; k < n_typed; k++) begin
				pending_replies.push_back(typed_tab[typed_pos]);
				typed_pos++;
			end
			replies_due += n_typed;
		end else begin
			for (k = 0; k < n; k++)
				pending_replies.push_back(step_out[k]);
			replies_due += n;
		end
		items_sent++;
	endtask

	task automatic send_ticks(int count);
		repeat (count)
			send_item(CMD_TICK, byte_t'($urandom_range(0, 255)),
				16'($urandom_range(0, 16'hFFFF)), 0);
	endtask

	// Drains the block, lets a frame walk finish, then writes the silence limit.
	task automatic set_silence(logic [15:0] value);
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		wr_en   <= 1'b1;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		sil_limit = value;
		settings_used++;
	endtask

	// One frame with random content, framed by enough silence to end it, or line noise.
	task automatic run_sequence();
		byte_t fr [$];
		byte_t x;
		int    sel;
		int    idx;
		int    lead;
		int    trail;
		int    sent_before;
		sent_before = items_sent;
		idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1, 2, 9: begin
				fr.push_back(HEAD_SET);
				repeat (9) fr.push_back(byte_t'($urandom_range(0, 255)));
				if ($urandom_range(0, 1) == 0)
					fr[9] = 8'h00;
			end
			3, 4: begin
				fr.push_back(HEAD_GETP);
			end
			5, 6: begin
				fr.push_back(HEAD_GETV);
			end
			7: begin
				if ($urandom_range(0, 1) == 0) begin
					fr.push_back(HEAD_SET);
				end else begin
					fr.push_back($urandom_range(0, 1) ? HEAD_GETP : HEAD_GETV);
					repeat (9) fr.push_back(byte_t'($urandom_range(0, 255)));
				end
			end
			default: begin
				repeat ($urandom_range(1, 40)) fr.push_back(byte_t'($urandom_range(0, 255)));
			end
		endcase
		// Close the frame with its check byte, except for raw noise.
		if (sel != 8) begin
			x = 8'h00;
			foreach (fr[i])
				x ^= fr[i];
			fr.push_back(x);
		end
		if (sel == 9) begin
			idx = $urandom_range(1, fr.size() - 1);
			fr[idx] = fr[idx] ^ (8'h01 << $urandom_range(0, 7));
		end
		lead = ((sil_limit == 16'd0) ? 1 : sil_limit) + $urandom_range(0, 2);
		if (sel == 8 && $urandom_range(0, 3) == 0)
			trail = $urandom_range(0, sil_limit);
		else
			trail = lead;
		send_ticks(lead);
		foreach (fr[i]) begin
			send_item(CMD_BYTE, fr[i], 16'($urandom_range(0, 16'hFFFF)), 0);
			if (sel == 8 && $urandom_range(0, 7) == 0)
				send_ticks($urandom_range(0, sil_limit));
		end
		send_ticks(trail);
		rand_items += items_sent - sent_before;
	endtask

	// Receiver stalls in random bursts while idling is allowed.
	always @(posedge clk) begin
		if (stall_left != 0)
			stall_left = stall_left - 1;
		else if (idle_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 15);
		out_stall <= (stall_left != 0);
	end

	// Every accepted reply is checked against the oldest outstanding one.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			check_reply({kind, tx_byte, last, vdc_min, vdc_max, vdc_critic, vdc_speed,
				chopper_on});
			replies_seen++;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at a one-tick silence limit.
		idle_on = 1'b1;
		set_silence(16'd1);
		foreach (dir_tab[i])
			send_item(dir_tab[i].cmd, dir_tab[i].rx, dir_tab[i].vdc, dir_tab[i].n_typed);

		// Random frames over several silence limits.
		foreach (sil_list[s]) begin
			set_silence(sil_list[s]);
			repeat (2) run_sequence();
		end
		while (replies_due < REPLY_TARGET)
			run_sequence();

		// Closing stretch without idling on either side.
		quiet = 1'b1;
		idle_on = 1'b0;
		set_silence(16'd1);
		repeat (4) run_sequence();

		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d input items (%0d in random frames) and %0d checked replies,",
			items_sent, rand_items, replies_seen);
		$display("over %0d silence limit writes, zero among them.", settings_used);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
